[rtl/itsn_pkg.sv]
// ----------------------------------------------------------------------------
// itsn_pkg: shared types, constants and tables
// Character codes, the per-stamp record passed from the front end to the
// arithmetic back end, and the small lookup tables used by the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package itsn_pkg;

    localparam int MAX_FRAC_DIGITS_DEF = 9;

    localparam int POS_W   = 5;
    localparam int YEAR_W  = 14;
    localparam int FIELD_W = 7;
    localparam int FRAC_W  = 30;
    localparam int CNT_W   = 4;
    localparam int FDIG_W  = 4;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // One finished stamp, all fields already accumulated
    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [FIELD_W-1:0] month;
        logic [FIELD_W-1:0] day;
        logic [FIELD_W-1:0] hour;
        logic [FIELD_W-1:0] minute;
        logic [FIELD_W-1:0] second;
        logic [FRAC_W-1:0]  frac;
        logic [CNT_W-1:0]   frac_cnt;
        logic               bad;
    } t_stamp;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Day of a March-based year on which the month starts
    function automatic logic [8:0] month_start(input logic [FIELD_W-1:0] m);
        logic [8:0] r;
        begin
            unique case (m)
                7'd3:    r = 9'd0;
                7'd4:    r = 9'd31;
                7'd5:    r = 9'd61;
                7'd6:    r = 9'd92;
                7'd7:    r = 9'd122;
                7'd8:    r = 9'd153;
                7'd9:    r = 9'd184;
                7'd10:   r = 9'd214;
                7'd11:   r = 9'd245;
                7'd12:   r = 9'd275;
                7'd1:    r = 9'd306;
                7'd2:    r = 9'd337;
                default: r = 9'd0;
            endcase
            return r;
        end
    endfunction

    // Scale for a fraction of cnt digits: 10^(9-cnt)
    function automatic logic [FRAC_W-1:0] frac_scale(input logic [CNT_W-1:0] cnt);
        logic [FRAC_W-1:0] r;
        begin
            unique case (cnt)
                4'd0:    r = 30'd1000000000;
                4'd1:    r = 30'd100000000;
                4'd2:    r = 30'd10000000;
                4'd3:    r = 30'd1000000;
                4'd4:    r = 30'd100000;
                4'd5:    r = 30'd10000;
                4'd6:    r = 30'd1000;
                4'd7:    r = 30'd100;
                4'd8:    r = 30'd10;
                default: r = 30'd1;
            endcase
            return r;
        end
    endfunction

endpackage

`default_nettype wire

[rtl/iso_timestamp_text_to_nanoseconds.sv]
// ----------------------------------------------------------------------------
// iso_timestamp_text_to_nanoseconds: timestamp text to epoch nanoseconds
// Parses YYYY-MM-DDTHH:MM:SS[.fff...] one character per transfer and
// returns nanoseconds since 1970-01-01 UTC with a format error flag.
//
// Channel   Dir  Transfer                 Payload
// s_axis    in   one character            tdata = char_code, tuser = stamp_start
// m_axis    out  one result per stamp     tdata = time_ns, tuser = bad_format
// cfg       in   fraction_digits write    i_cfg_data
//
// One character is taken per cycle while the record queue is not full; the
// record of a stamp is queued on the edge that takes its last character, then
// passes seven arithmetic stages and the output register. Reset clears
// position, accumulators, queue and pipe valid bits; fraction_digits resets
// to 0. A held result stalls the arithmetic pipe; characters keep flowing
// until the two-entry record queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module iso_timestamp_text_to_nanoseconds #(
    parameter int MAX_FRACTION_DIGITS = itsn_pkg::MAX_FRAC_DIGITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_valid,
    output      logic                        o_cfg_ready,
    input  wire logic [itsn_pkg::FDIG_W-1:0] i_cfg_data,   // fraction_digits
    input  wire logic                        s_axis_tvalid,
    output      logic                        s_axis_tready,
    input  wire logic [7:0]                  s_axis_tdata,  // [7:0] char_code
    input  wire logic                        s_axis_tuser,  // [0] stamp_start
    output      logic                        m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output      logic [63:0]                 m_axis_tdata,  // [63:0] time_ns
    output      logic                        m_axis_tuser   // [0] bad_format
);
    import itsn_pkg::*;

    logic    w_push;
    logic    w_pop;
    t_stamp  w_front_rec;
    t_stamp  w_head_rec;
    t_q_stat w_qstat;

    assign o_cfg_ready = 1'b1;

    itsn_front #(
        .MAX_FRACTION_DIGITS(MAX_FRACTION_DIGITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_char     (s_axis_tdata),
        .i_start    (s_axis_tuser),
        .i_qstat    (w_qstat),
        .o_push     (w_push),
        .o_rec      (w_front_rec)
    );

    itsn_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_rec  (w_front_rec),
        .i_pop  (w_pop),
        .o_rec  (w_head_rec),
        .o_stat (w_qstat)
    );

    itsn_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rec    (w_head_rec),
        .i_qstat  (w_qstat),
        .o_pop    (w_pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_time_ns(m_axis_tdata),
        .o_bad    (m_axis_tuser)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_qstat.full && !w_pop))
        else $error("record pushed into a full queue");

    a_push_on_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (s_axis_tvalid && s_axis_tready))
        else $error("record pushed without an input transfer");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_qstat.empty)
        else $error("record popped from an empty queue");

endmodule

`default_nettype wire

[rtl/itsn_front.sv]
// ----------------------------------------------------------------------------
// itsn_front: character front end
// Tracks the character position, checks separators and digits, accumulates
// the decimal fields and emits one record per completed stamp.
// ----------------------------------------------------------------------------
`default_nettype none

module itsn_front #(
    parameter int MAX_FRACTION_DIGITS = itsn_pkg::MAX_FRAC_DIGITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_valid,
    input  wire logic [itsn_pkg::FDIG_W-1:0] i_cfg_data,
    input  wire logic                       i_valid,
    output      logic                       o_ready,
    input  wire logic [7:0]                 i_char,
    input  wire logic                       i_start,
    input  wire itsn_pkg::t_q_stat          i_qstat,
    output      logic                       o_push,
    output      itsn_pkg::t_stamp           o_rec
);
    import itsn_pkg::*;

    localparam logic [POS_W-1:0] P_DASH1  = POS_W'(4);
    localparam logic [POS_W-1:0] P_DASH2  = POS_W'(7);
    localparam logic [POS_W-1:0] P_T      = POS_W'(10);
    localparam logic [POS_W-1:0] P_COLON1 = POS_W'(13);
    localparam logic [POS_W-1:0] P_COLON2 = POS_W'(16);
    localparam logic [POS_W-1:0] P_DOT    = POS_W'(19);
    localparam logic [POS_W-1:0] P_FRAC0  = POS_W'(20);
    localparam logic [POS_W-1:0] P_NOFRAC = POS_W'(18);
    localparam logic [FDIG_W-1:0] FD_MAX  = FDIG_W'(MAX_FRACTION_DIGITS);

    logic [FDIG_W-1:0]  r_fdig;
    logic [POS_W-1:0]   r_pos,    n_pos;
    logic [YEAR_W-1:0]  r_year,   n_year;
    logic [FIELD_W-1:0] r_month,  n_month;
    logic [FIELD_W-1:0] r_day,    n_day;
    logic [FIELD_W-1:0] r_hour,   n_hour;
    logic [FIELD_W-1:0] r_minute, n_minute;
    logic [FIELD_W-1:0] r_second, n_second;
    logic [FRAC_W-1:0]  r_frac,   n_frac;
    logic               r_err,    n_err;

    logic               w_accept;
    logic [FDIG_W-1:0]  w_fd;
    logic [POS_W-1:0]   w_last;
    logic               w_end;
    logic               w_digit;
    logic [3:0]         w_dval;
    logic [POS_W-1:0]   w_cnt;

    assign o_ready  = !i_qstat.full;
    assign w_accept = i_valid && o_ready;

    assign w_fd    = (r_fdig > FD_MAX) ? FD_MAX : r_fdig;
    assign w_last  = (w_fd != '0) ? POS_W'(P_DOT + POS_W'(w_fd)) : P_NOFRAC;
    assign w_digit = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
    assign w_dval  = w_digit ? 4'(i_char - CH_ZERO) : 4'd0;

    always_comb begin
        logic [POS_W-1:0] p;
        p        = i_start ? '0 : r_pos;
        n_year   = i_start ? '0 : r_year;
        n_month  = i_start ? '0 : r_month;
        n_day    = i_start ? '0 : r_day;
        n_hour   = i_start ? '0 : r_hour;
        n_minute = i_start ? '0 : r_minute;
        n_second = i_start ? '0 : r_second;
        n_frac   = i_start ? '0 : r_frac;
        n_err    = i_start ? 1'b0 : r_err;

        if (p == P_DASH1 || p == P_DASH2) begin
            if (i_char != CH_DASH) n_err = 1'b1;
        end else if (p == P_T) begin
            if (i_char != CH_T) n_err = 1'b1;
        end else if (p == P_COLON1 || p == P_COLON2) begin
            if (i_char != CH_COLON) n_err = 1'b1;
        end else if (p == P_DOT) begin
            if (i_char != CH_DOT) n_err = 1'b1;
        end else begin
            if (!w_digit) n_err = 1'b1;
            if (p < P_DASH1)
                n_year = YEAR_W'(n_year * YEAR_W'(10) + YEAR_W'(w_dval));
            else if (p < P_DASH2)
                n_month = FIELD_W'(n_month * FIELD_W'(10) + FIELD_W'(w_dval));
            else if (p < P_T)
                n_day = FIELD_W'(n_day * FIELD_W'(10) + FIELD_W'(w_dval));
            else if (p < P_COLON1)
                n_hour = FIELD_W'(n_hour * FIELD_W'(10) + FIELD_W'(w_dval));
            else if (p < P_COLON2)
                n_minute = FIELD_W'(n_minute * FIELD_W'(10) + FIELD_W'(w_dval));
            else if (p < P_DOT)
                n_second = FIELD_W'(n_second * FIELD_W'(10) + FIELD_W'(w_dval));
            else
                n_frac = FRAC_W'(n_frac * FRAC_W'(10) + FRAC_W'(w_dval));
        end

        w_end = (p >= w_last);
        n_pos = w_end ? '0 : POS_W'(p + POS_W'(1));
        // digits seen after the dot, by position
        w_cnt = (p >= P_FRAC0) ? POS_W'(p - P_DOT) : '0;
    end

    always_comb begin
        o_rec.year     = n_year;
        o_rec.month    = n_month;
        o_rec.day      = n_day;
        o_rec.hour     = n_hour;
        o_rec.minute   = n_minute;
        o_rec.second   = n_second;
        o_rec.frac     = n_frac;
        o_rec.frac_cnt = (w_cnt > POS_W'(9)) ? CNT_W'(9) : CNT_W'(w_cnt);
        o_rec.bad      = n_err || (n_month < FIELD_W'(1)) || (n_month > FIELD_W'(12));
    end

    assign o_push = w_accept && w_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fdig <= '0;
        end else if (i_cfg_valid) begin
            r_fdig <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_year   <= '0;
            r_month  <= '0;
            r_day    <= '0;
            r_hour   <= '0;
            r_minute <= '0;
            r_second <= '0;
            r_frac   <= '0;
            r_err    <= 1'b0;
        end else if (w_accept) begin
            r_pos <= n_pos;
            if (w_end) begin
                r_year   <= '0;
                r_month  <= '0;
                r_day    <= '0;
                r_hour   <= '0;
                r_minute <= '0;
                r_second <= '0;
                r_frac   <= '0;
                r_err    <= 1'b0;
            end else begin
                r_year   <= n_year;
                r_month  <= n_month;
                r_day    <= n_day;
                r_hour   <= n_hour;
                r_minute <= n_minute;
                r_second <= n_second;
                r_frac   <= n_frac;
                r_err    <= n_err;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/itsn_queue.sv]
// ----------------------------------------------------------------------------
// itsn_queue: stamp record queue
// Two-entry register queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module itsn_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire itsn_pkg::t_stamp  i_rec,
    input  wire logic              i_pop,
    output      itsn_pkg::t_stamp  o_rec,
    output      itsn_pkg::t_q_stat o_stat
);
    import itsn_pkg::*;

    t_stamp              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr_ptr;
    logic [Q_PTR_W-1:0]  r_rd_ptr;
    logic [Q_CNT_W-1:0]  r_count;

    assign o_stat.full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_rec        = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= Q_PTR_W'(r_wr_ptr + 1'b1);
            if (i_pop)  r_rd_ptr <= Q_PTR_W'(r_rd_ptr + 1'b1);
            case ({i_push, i_pop})
                2'b10:   r_count <= Q_CNT_W'(r_count + 1'b1);
                2'b01:   r_count <= Q_CNT_W'(r_count - 1'b1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/itsn_back.sv]
// ----------------------------------------------------------------------------
// itsn_back: date and time arithmetic pipeline
// Eight-stage pipeline turning a stamp record into nanoseconds since the
// epoch. The whole pipe advances unless the output register is held.
// ----------------------------------------------------------------------------
`default_nettype none

module itsn_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire itsn_pkg::t_stamp  i_rec,
    input  wire itsn_pkg::t_q_stat i_qstat,
    output      logic              o_pop,
    output      logic              o_valid,
    input  wire logic              i_ready,
    output      logic [63:0]       o_time_ns,
    output      logic              o_bad
);
    import itsn_pkg::*;

    // 719468 days to the epoch, plus 146097 for the 400-year shift, plus 1
    localparam logic signed [24:0] DAYS_BIAS = 25'sd865566;
    localparam logic [12:0] RECIP_25 = 13'd5243;   // 2^17 / 25, rounded up

    logic [8:1] r_v;
    logic       w_en;

    // stage 1
    logic [14:0] r_y1;
    logic [8:0]  r_doy1;
    logic [18:0] r_sec1;
    logic [FRAC_W-1:0] r_frac1, r_scale1;
    logic        r_bad1;
    // stage 2
    logic [23:0] r_y365_2;
    logic [12:0] r_q4_2;
    logic [25:0] r_c100_2;
    logic [23:0] r_c400_2;
    logic [59:0] r_fp2;
    logic [8:0]  r_doy2;
    logic [18:0] r_sec2;
    logic        r_bad2;
    // stage 3
    logic signed [23:0] r_days3;
    logic [59:0] r_fp3;
    logic [18:0] r_sec3;
    logic        r_bad3;
    // stage 4
    logic signed [39:0] r_dsec4;
    logic [59:0] r_fp4;
    logic [18:0] r_sec4;
    logic        r_bad4;
    // stage 5
    logic signed [39:0] r_s5;
    logic [59:0] r_fp5;
    logic        r_bad5;
    // stage 6
    logic signed [50:0] r_ph6;
    logic [49:0] r_pl6;
    logic [59:0] r_fp6;
    logic        r_bad6;
    // stage 7
    logic [63:0] r_sum7;
    logic [59:0] r_fp7;
    logic        r_bad7;
    // stage 8
    logic [63:0] r_t8;
    logic        r_bad8;

    logic        w_jan_feb;
    logic [18:0] w_secs;
    logic signed [24:0] w_days;
    logic signed [41:0] w_dsec;
    logic signed [50:0] w_ph;

    assign w_en    = !r_v[8] || i_ready;
    assign o_pop   = w_en && !i_qstat.empty;
    assign o_valid = r_v[8];
    assign o_time_ns = r_t8;
    assign o_bad   = r_bad8;

    assign w_jan_feb = (i_rec.month <= FIELD_W'(2));
    assign w_secs = 19'(i_rec.hour) * 19'd3600 + 19'(i_rec.minute) * 19'd60
                  + 19'(i_rec.second);

    // 365*Y + Y/4 - Y/100 + Y/400 + day of year, over a year shifted up by 400
    assign w_days = 25'(r_y365_2) + 25'(r_q4_2) - 25'(r_c100_2[25:17])
                  + 25'(r_c400_2[23:17]) + 25'(r_doy2) - DAYS_BIAS;
    assign w_dsec = 42'(r_days3) * 42'sd86400;
    assign w_ph   = 51'($signed(r_s5[39:20])) * 51'sd1000000000;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[7:1], !i_qstat.empty};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_y1     <= 15'(i_rec.year) + 15'd400 - 15'(w_jan_feb);
            r_doy1   <= month_start(i_rec.month) + 9'(i_rec.day);
            r_sec1   <= w_secs;
            r_frac1  <= i_rec.frac;
            r_scale1 <= frac_scale(i_rec.frac_cnt);
            r_bad1   <= i_rec.bad;

            r_y365_2 <= 24'(r_y1) * 24'd365;
            r_q4_2   <= r_y1[14:2];
            r_c100_2 <= 26'(r_y1[14:2]) * 26'(RECIP_25);
            r_c400_2 <= 24'(r_y1[14:4]) * 24'(RECIP_25);
            r_fp2    <= 60'(r_frac1) * 60'(r_scale1);
            r_doy2   <= r_doy1;
            r_sec2   <= r_sec1;
            r_bad2   <= r_bad1;

            r_days3  <= w_days[23:0];
            r_fp3    <= r_fp2;
            r_sec3   <= r_sec2;
            r_bad3   <= r_bad2;

            r_dsec4  <= w_dsec[39:0];
            r_fp4    <= r_fp3;
            r_sec4   <= r_sec3;
            r_bad4   <= r_bad3;

            r_s5     <= r_dsec4 + $signed(40'(r_sec4));
            r_fp5    <= r_fp4;
            r_bad5   <= r_bad4;

            // seconds split in a signed high half and an unsigned low half
            r_ph6    <= w_ph;
            r_pl6    <= 50'(r_s5[19:0]) * 50'd1000000000;
            r_fp6    <= r_fp5;
            r_bad6   <= r_bad5;

            r_sum7   <= {r_ph6[43:0], 20'd0} + 64'(r_pl6);
            r_fp7    <= r_fp6;
            r_bad7   <= r_bad6;

            r_t8     <= r_bad7 ? 64'd0 : r_sum7 + 64'(r_fp7);
            r_bad8   <= r_bad7;
        end
    end

endmodule

`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for iso_timestamp_text_to_nanoseconds
// Streams timestamp text one character per transfer. A behavioral parser
// predicts each result, which is compared field by field with the output.
// A directed table comes first, then random stamps with noise under random
// back-pressure on both streams.
// ----------------------------------------------------------------------------
module testbench;
    import itsn_pkg::*;

    localparam int MAX_FD        = MAX_FRAC_DIGITS_DEF;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 16;
    localparam int N_ROWS        = 25;
    localparam int PHASE_CHARS   = 125;

    typedef struct packed {
        logic [63:0] ns;
        logic        bad;
    } t_result;

    typedef struct {
        string    text;
        int       fdig;
        bit       first_start;
        bit       fixed;
        longint   ns;
        bit       bad;
    } t_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [FDIG_W-1:0]   i_cfg_data = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata = '0;   // [7:0] char_code
    logic                s_axis_tuser = 1'b0; // [0] stamp_start
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [63:0]         m_axis_tdata;        // [63:0] time_ns
    logic                m_axis_tuser;        // [0] bad_format

    // parser state mirrored by the bench
    logic [FDIG_W-1:0]   frac_digits_reg;
    logic [POS_W-1:0]    cur_pos;
    logic [YEAR_W-1:0]   acc_year;
    logic [FIELD_W-1:0]  acc_month, acc_day, acc_hour, acc_min, acc_sec;
    logic [FRAC_W-1:0]   acc_frac;
    logic                fmt_err;

    t_result pending_stamps[$];
    int      errors = 0;
    int      chars_sent = 0;
    int      stall_cycles = 0;
    int      sink_hold = 0;
    bit      src_idle = 0;
    bit      sink_idle = 0;

    t_row dir_rows [N_ROWS] = '{
        '{"1970-01-01T00:00:00",            0,  1, 1, 0,           0},
        '{"0000-01-01T00:00:00",            0,  1, 0, 0,           0},
        '{"9999-12-31T23:59:59",            0,  1, 0, 0,           0},
        '{"2000-02-29T12:34:56",            0,  1, 0, 0,           0},
        '{"1969-12-31T23:59:59",            0,  1, 1, -1000000000, 0},
        // next stamp follows with no start flag
        '{"1970-01-02T00:00:00",            0,  0, 0, 0,           0},
        '{"2024-13-01T00:00:00",            0,  1, 1, 0,           1},
        '{"2024-00-10T00:00:00",            0,  1, 1, 0,           1},
        '{"2024/01-01T00:00:00",            0,  1, 1, 0,           1},
        '{"2024-01-01 00:00:00",            0,  1, 1, 0,           1},
        '{"2024-01-01T00-00:00",            0,  1, 1, 0,           1},
        '{"20a4-01-01T00:00:00",            0,  1, 1, 0,           1},
        '{"2023-02-99T99:99:99",            0,  1, 0, 0,           0},
        '{"9999-99-99T99:99:99",            0,  1, 1, 0,           1},
        // abandoned stamp, restarted by the start flag
        '{"2024-05-",                       0,  1, 0, 0,           0},
        '{"2024-05-06T07:08:09",            0,  1, 0, 0,           0},
        '{"2024-06-15T08:30:00.123456789",  9,  1, 0, 0,           0},
        '{"1970-01-01T00:00:00.000000001",  9,  1, 1, 1,           0},
        '{"9999-12-31T23:59:59.999999999",  9,  1, 0, 0,           0},
        '{"2024-06-15T08:30:00,123456789",  9,  1, 1, 0,           1},
        '{"2024-06-15T08:30:00.99999999x",  9,  1, 1, 0,           1},
        // register above the digit limit saturates
        '{"1970-01-01T00:00:00.999999999",  15, 1, 1, 999999999,   0},
        '{"2024-06-15T08:30:00.500",        3,  1, 0, 0,           0},
        // digit count shrinks while a stamp is open
        '{"2024-06-15T08:30:00.12",         3,  1, 0, 0,           0},
        '{"3",                              0,  0, 0, 0,           0}
    };

    iso_timestamp_text_to_nanoseconds u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic void clear_fields();
        cur_pos   = '0;
        acc_year  = '0;
        acc_month = '0;
        acc_day   = '0;
        acc_hour  = '0;
        acc_min   = '0;
        acc_sec   = '0;
        acc_frac  = '0;
        fmt_err   = 1'b0;
    endfunction

    // Advance the parser by one character; returns 1 when a stamp completes
    function automatic bit parse_text_char(input logic [7:0] c, input logic st,
                                           output t_result r);
        logic [POS_W-1:0] last_pos, p;
        int unsigned      f, dv, cnt;
        bit               is_dig;
        longint           y, m, d, era, yoe, doy, doe, days;
        longint unsigned  secs, scale;
        if (st)
            clear_fields();
        f        = frac_digits_reg > MAX_FD ? MAX_FD : frac_digits_reg;
        last_pos = f != 0 ? POS_W'(19 + f) : POS_W'(18);
        p        = cur_pos;
        is_dig   = c >= CH_ZERO && c <= CH_NINE;
        dv       = is_dig ? c - CH_ZERO : 0;
        case (p)
            4, 7: begin
                if (c != CH_DASH) fmt_err = 1'b1;
            end
            10: begin
                if (c != CH_T) fmt_err = 1'b1;
            end
            13, 16: begin
                if (c != CH_COLON) fmt_err = 1'b1;
            end
            19: begin
                if (c != CH_DOT) fmt_err = 1'b1;
            end
            default: begin
                if (!is_dig) fmt_err = 1'b1;
                if (p < 4)       acc_year  = YEAR_W'(acc_year * 10 + dv);
                else if (p < 7)  acc_month = FIELD_W'(acc_month * 10 + dv);
                else if (p < 10) acc_day   = FIELD_W'(acc_day * 10 + dv);
                else if (p < 13) acc_hour  = FIELD_W'(acc_hour * 10 + dv);
                else if (p < 16) acc_min   = FIELD_W'(acc_min * 10 + dv);
                else if (p < 19) acc_sec   = FIELD_W'(acc_sec * 10 + dv);
                else             acc_frac  = FRAC_W'(acc_frac * 10 + dv);
            end
        endcase
        if (p < last_pos) begin
            cur_pos = p + 1'b1;
            return 1'b0;
        end
        r.bad = fmt_err || acc_month < 1 || acc_month > 12;
        r.ns  = '0;
        if (!r.bad) begin
            cnt = p >= 20 ? p - 19 : 0;
            if (cnt > 9) cnt = 9;
            scale = 1;
            repeat (9 - cnt) scale = scale * 10;
            // days from civil date, March-based year
            y = acc_year;
            m = acc_month;
            d = acc_day;
            if (m <= 2) y = y - 1;
            era  = (y >= 0 ? y : y - 399) / 400;
            yoe  = y - era * 400;
            doy  = (153 * (m > 2 ? m - 3 : m + 9) + 2) / 5 + d - 1;
            doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
            days = era * 146097 + doe - 719468;
            secs = longint'(acc_hour) * 3600 + longint'(acc_min) * 60 + acc_sec;
            r.ns = days * 64'd86400000000000 + secs * 64'd1000000000 + acc_frac * scale;
        end
        clear_fields();
        return 1'b1;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 9) != 0)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int pick_field(input int lo, input int hi);
        if ($urandom_range(0, 6) == 0)
            return $urandom_range(0, 99);
        return $urandom_range(lo, hi);
    endfunction

    task automatic send_char(input logic [7:0] c, input logic st);
        t_result r;
        int      gap;
        gap = (src_idle && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tuser  <= st;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        chars_sent++;
        if (parse_text_char(c, st, r))
            pending_stamps.push_back(r);
    endtask

    // Drain all results before touching the register
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_stamps.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_frac_digits(input logic [FDIG_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        frac_digits_reg = v;
    endtask

    task automatic send_random_stamp(input bit resume, input bit force_cut);
        logic [7:0] txt[$];
        string      s;
        int         eff, kind, stop;
        logic       st;
        eff = frac_digits_reg > MAX_FD ? MAX_FD : frac_digits_reg;
        s = $sformatf("%04d-%02d-%02dT%02d:%02d:%02d", $urandom_range(0, 9999),
                      pick_field(1, 12), pick_field(1, 28), pick_field(0, 23),
                      pick_field(0, 59), pick_field(0, 59));
        if (eff != 0) begin
            s = {s, "."};
            repeat (eff) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
        end
        for (int k = 0; k < s.len(); k++)
            txt.push_back(s[k]);
        kind = force_cut ? 85 : $urandom_range(0, 99);
        stop = txt.size();
        if (kind >= 70 && kind < 82) begin
            txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
        end else if (kind >= 82 && kind < 92) begin
            stop = $urandom_range(1, txt.size() - 1);
        end else if (kind >= 92) begin
            foreach (txt[j]) txt[j] = 8'($urandom_range(0, 255));
        end
        if (resume)
            st = 1'b0;
        else if (cur_pos != 0)
            st = 1'b1;
        else
            st = $urandom_range(0, 4) != 0;
        for (int k = 0; k < stop; k++) begin
            // noise stamps may restart at any character
            if (k == 0)
                send_char(txt[k], st);
            else
                send_char(txt[k], kind >= 92 && $urandom_range(0, 15) == 0);
        end
    endtask

    // output side: random back-pressure
    always @(posedge i_clk) begin
        if (sink_hold != 0) begin
            sink_hold     <= sink_hold - 1;
            m_axis_tready <= 1'b0;
        end else if (sink_idle && $urandom_range(0, 4) == 0) begin
            sink_hold     <= pick_gap();
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_stamps.size() == 0) begin
                $error("unexpected result: time_ns %0d bad_format %0b",
                       $signed(m_axis_tdata), m_axis_tuser);
                errors++;
            end else begin
                want = pending_stamps.pop_front();
                if (m_axis_tdata !== want.ns) begin
                    $error("time_ns mismatch: expected %0d actual %0d",
                           $signed(want.ns), $signed(m_axis_tdata));
                    errors++;
                end
                if (m_axis_tuser !== want.bad) begin
                    $error("bad_format mismatch: expected %0b actual %0b",
                           want.bad, m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int fd;
        int phase_end;
        bit resume;
        bit leave_open;
        frac_digits_reg = '0;
        clear_fields();
        leave_open = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        src_idle  = 1;
        sink_idle = 1;
        foreach (dir_rows[i]) begin
            if (dir_rows[i].fdig != frac_digits_reg) begin
                wait_idle();
                write_frac_digits(FDIG_W'(dir_rows[i].fdig));
            end
            for (int k = 0; k < dir_rows[i].text.len(); k++)
                send_char(dir_rows[i].text[k], k == 0 && dir_rows[i].first_start);
            if (dir_rows[i].fixed)
                pending_stamps[pending_stamps.size() - 1] = '{dir_rows[i].ns, dir_rows[i].bad};
        end

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: fd = 0;
                1: fd = MAX_FD;
                2: fd = 15;
                default: fd = $urandom_range(0, 15);
            endcase
            src_idle  = ph != 0;
            sink_idle = ph > 1;
            wait_idle();
            write_frac_digits(FDIG_W'(fd));
            resume    = leave_open && $urandom_range(0, 1);
            phase_end = chars_sent + PHASE_CHARS;
            while (chars_sent < phase_end) begin
                send_random_stamp(resume, 1'b0);
                resume = 0;
            end
            if ($urandom_range(0, 2) == 0)
                send_random_stamp(1'b0, 1'b1);
            leave_open = cur_pos != 0;
        end

        s_axis_tvalid <= 1'b0;
        while (pending_stamps.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending_stamps.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
